// ===== sv/swss_pkg.sv =====
// Package for the spring water surface: sizes, fixed-point formats, op codes and shared types.
`default_nettype none
package swss_pkg;

    // Number of columns held in the row of cells.
    localparam int MAX_COLUMNS   = 32;
    // Neighbor passes run after the spring update of a tick.
    localparam int SPREAD_PASSES = 8;

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int N_W    = 7;                       // holds column_count and MAX_COLUMNS
    localparam int PASS_W = $clog2(SPREAD_PASSES + 1);

    localparam int Q_W    = 24;                      // Q12.12 height and speed
    localparam int DIFF_W = 25;                      // difference of two Q12.12 values
    localparam int COEF_W = 16;                      // unsigned Q0.16 coefficient
    localparam int PROD_W = 42;                      // signed product of coefficient and difference
    localparam int SH_W   = PROD_W - 16;             // product after the Q0.16 shift
    localparam int ACC_W  = 28;                      // sums before saturation

    localparam logic signed [Q_W-1:0] Q_MAX = 24'sh7FFFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 24'sh800000;

    localparam logic [22:0] REST_RESET = 23'd81920;

    // Input kinds.
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_SPLASH  = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_COUNT   = 3'd0;
    localparam logic [2:0] CFG_REST    = 3'd1;
    localparam logic [2:0] CFG_TENSION = 3'd2;
    localparam logic [2:0] CFG_DAMPING = 3'd3;
    localparam logic [2:0] CFG_SPREAD  = 3'd4;
    localparam logic [2:0] CFG_DRAG_X  = 3'd5;
    localparam logic [2:0] CFG_DRAG_Y  = 3'd6;

    // Operations broadcast to every cell.
    localparam logic [3:0] OP_IDLE     = 4'd0;
    localparam logic [3:0] OP_SPRING_T = 4'd1;
    localparam logic [3:0] OP_SPRING_D = 4'd2;
    localparam logic [3:0] OP_SPRING_S = 4'd3;
    localparam logic [3:0] OP_SPRING_H = 4'd4;
    localparam logic [3:0] OP_SPREAD_L = 4'd5;
    localparam logic [3:0] OP_SPREAD_R = 4'd6;
    localparam logic [3:0] OP_SPREAD_U = 4'd7;
    localparam logic [3:0] OP_RESTART  = 4'd8;
    localparam logic [3:0] OP_SPLASH   = 4'd9;
    localparam logic [3:0] OP_SNAP     = 4'd10;
    localparam logic [3:0] OP_SHIFT    = 4'd11;

    typedef struct packed {
        logic [3:0]            op;
        logic [COEF_W-1:0]     coef;
        logic [22:0]           rest;
        logic signed [Q_W-1:0] splash_speed;
    } t_cell_ctrl;

    typedef struct packed {
        logic active;
        logic left_en;
        logic right_en;
        logic hit;
    } t_cell_flags;

    // Clamp a wide signed sum into the Q12.12 range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [ACC_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > ACC_W'(Q_MAX)) begin
            r = Q_MAX;
        end else if (v < ACC_W'(Q_MIN)) begin
            r = Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/spring_water_surface_step.sv =====
// Top level of the spring water surface: configuration, sequencer, cell row and output stage.
// Usage:
//   Commands enter as beats on the s_axis channel. tuser carries the kind (tick, splash,
//   restart); tdata carries the splash column and the two body velocities. Heights leave
//   as beats on the m_axis channel, one per active column in column order, with tlast on
//   the final column of a tick.
//   Work happens in a row of identical cells, one per column. Each cell has one multiplier
//   and sees the heights of its two neighbors; a broadcast operation steps all cells at once.
//   A tick runs the spring update (two products, speed, height), then each of the eight
//   neighbor passes (left product, right product, update), and then copies the heights
//   into the readout chain. The heights then shift out of the chain through the output
//   register, one beat a cycle while the receiver takes them. A splash takes the
//   accepting cycle, a multiply for each velocity and the write, and a restart takes the
//   accepting cycle and the write; neither gives any beat.
//   One command is worked on at a time: s_axis_tready is high while the sequencer is idle,
//   which includes the time the final height of a tick still waits in the output register.
//   When the receiver stalls, the readout chain holds and the tick waits at its readout.
//   A synchronous reset restores the register defaults, puts every column at the default
//   rest level with zero speed, and empties the output register.
`default_nettype none
module spring_water_surface_step
    import swss_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Command channel.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [55:0] s_axis_tdata,   // column[4:0], vel_x[28:5], vel_y[52:29], zero pad
    input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
    // Height channel.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // out_column[4:0], height[28:5], zero pad
    output logic             m_axis_tlast,
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [22:0] i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SPRING  = 3'd1;
    localparam logic [2:0] ST_SPREAD  = 3'd2;
    localparam logic [2:0] ST_SNAP    = 3'd3;
    localparam logic [2:0] ST_OUT     = 3'd4;
    localparam logic [2:0] ST_SPLASH  = 3'd5;
    localparam logic [2:0] ST_RESTART = 3'd6;

    // Configuration registers.
    logic [5:0]        r_count;
    logic [22:0]       r_rest;
    logic [COEF_W-1:0] r_tension;
    logic [COEF_W-1:0] r_damping;
    logic [COEF_W-1:0] r_spread;
    logic [COEF_W-1:0] r_drag_x;
    logic [COEF_W-1:0] r_drag_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= 6'd20;
            r_rest    <= REST_RESET;
            r_tension <= 16'd1638;
            r_damping <= 16'd1638;
            r_spread  <= 16'd16384;
            r_drag_x  <= 16'd655;
            r_drag_y  <= 16'd1966;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_COUNT:   r_count   <= i_cfg_data[5:0];
                CFG_REST:    r_rest    <= i_cfg_data;
                CFG_TENSION: r_tension <= i_cfg_data[15:0];
                CFG_DAMPING: r_damping <= i_cfg_data[15:0];
                CFG_SPREAD:  r_spread  <= i_cfg_data[15:0];
                CFG_DRAG_X:  r_drag_x  <= i_cfg_data[15:0];
                CFG_DRAG_Y:  r_drag_y  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Active column count, clamped to the size of the row.
    logic [N_W-1:0] w_n;
    assign w_n = (N_W'(r_count) > N_W'(MAX_COLUMNS)) ? N_W'(MAX_COLUMNS) : N_W'(r_count);

    // Sequencer.
    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [1:0]        r_step;
    logic [PASS_W-1:0] r_pass;
    logic [N_W-1:0]    r_left;
    logic [COL_W-1:0]  r_idx;
    logic [4:0]        r_column;
    logic signed [23:0] r_vel_x;
    logic signed [23:0] r_vel_y;

    logic w_accept;
    logic w_load;
    logic w_splash_done;
    logic signed [Q_W-1:0] w_splash_speed;

    logic                  r_out_valid;
    logic [4:0]            r_out_col;
    logic signed [Q_W-1:0] r_out_h;
    logic                  r_out_last;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    // A height moves from the chain head into the output register only when it is free or being emptied.
    assign w_load = (r_state == ST_OUT) && (r_left != '0) && (!r_out_valid || m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (s_axis_tuser)
                        KIND_TICK:    n_state = ST_SPRING;
                        KIND_SPLASH:  n_state = ST_SPLASH;
                        KIND_RESTART: n_state = ST_RESTART;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SPRING:  if (r_step == 2'd3) n_state = ST_SPREAD;
            ST_SPREAD: begin
                if (r_step == 2'd2 && r_pass == PASS_W'(SPREAD_PASSES - 1)) n_state = ST_SNAP;
            end
            ST_SNAP:    n_state = ST_OUT;
            ST_OUT:     if (r_left == '0) n_state = ST_IDLE;
            ST_SPLASH:  if (w_splash_done) n_state = ST_IDLE;
            ST_RESTART: n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= 2'd0;
            r_pass  <= '0;
            r_left  <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_step <= 2'd0;
                    r_pass <= '0;
                end
                ST_SPRING: begin
                    r_step <= (r_step == 2'd3) ? 2'd0 : r_step + 2'd1;
                end
                ST_SPREAD: begin
                    if (r_step == 2'd2) begin
                        r_step <= 2'd0;
                        r_pass <= r_pass + PASS_W'(1);
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end
                ST_SNAP: begin
                    r_left <= w_n;
                    r_idx  <= '0;
                end
                ST_OUT: begin
                    if (w_load) begin
                        r_left <= r_left - N_W'(1);
                        r_idx  <= r_idx + COL_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Command payload, held for the splash unit and the hit decode.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_column <= s_axis_tdata[4:0];
            r_vel_x  <= s_axis_tdata[28:5];
            r_vel_y  <= s_axis_tdata[52:29];
        end
    end

    swss_splash u_splash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept && s_axis_tuser == KIND_SPLASH),
        .i_vel_x  (r_vel_x),
        .i_vel_y  (r_vel_y),
        .i_drag_x (r_drag_x),
        .i_drag_y (r_drag_y),
        .o_done   (w_splash_done),
        .o_speed  (w_splash_speed)
    );

    // Operation broadcast to the cell row.
    t_cell_ctrl w_ctrl;
    always_comb begin
        w_ctrl.op           = OP_IDLE;
        w_ctrl.coef         = r_spread;
        w_ctrl.rest         = r_rest;
        w_ctrl.splash_speed = w_splash_speed;
        case (r_state)
            ST_SPRING: begin
                case (r_step)
                    2'd0:    w_ctrl.op = OP_SPRING_T;
                    2'd1:    w_ctrl.op = OP_SPRING_D;
                    2'd2:    w_ctrl.op = OP_SPRING_S;
                    default: w_ctrl.op = OP_SPRING_H;
                endcase
                if (r_step == 2'd0) w_ctrl.coef = r_tension;
                else                w_ctrl.coef = r_damping;
            end
            ST_SPREAD: begin
                case (r_step)
                    2'd0:    w_ctrl.op = OP_SPREAD_L;
                    2'd1:    w_ctrl.op = OP_SPREAD_R;
                    default: w_ctrl.op = OP_SPREAD_U;
                endcase
            end
            ST_SNAP:    w_ctrl.op = OP_SNAP;
            ST_OUT:     if (w_load) w_ctrl.op = OP_SHIFT;
            ST_SPLASH:  if (w_splash_done) w_ctrl.op = OP_SPLASH;
            ST_RESTART: w_ctrl.op = OP_RESTART;
            default:    w_ctrl.op = OP_IDLE;
        endcase
    end

    // The row of cells. Each cell sees its neighbors' heights and hands its readout
    // value toward column zero.
    logic signed [Q_W-1:0] w_h     [MAX_COLUMNS];
    logic signed [Q_W-1:0] w_shift [MAX_COLUMNS];

    for (genvar gi = 0; gi < MAX_COLUMNS; gi++) begin : g_cell
        t_cell_flags           w_flags;
        logic signed [Q_W-1:0] w_left_h;
        logic signed [Q_W-1:0] w_right_h;
        logic signed [Q_W-1:0] w_shift_in;

        if (gi == 0) begin : g_first
            assign w_left_h      = '0;
            assign w_flags.left_en = 1'b0;
        end else begin : g_inner
            assign w_left_h      = w_h[gi-1];
            assign w_flags.left_en = (N_W'(gi) < w_n);
        end

        if (gi == MAX_COLUMNS - 1) begin : g_last
            assign w_right_h  = '0;
            assign w_shift_in = '0;
        end else begin : g_body
            assign w_right_h  = w_h[gi+1];
            assign w_shift_in = w_shift[gi+1];
        end

        assign w_flags.active   = (N_W'(gi) < w_n);
        assign w_flags.right_en = (N_W'(gi + 1) < w_n);
        assign w_flags.hit      = (N_W'(r_column) == N_W'(gi)) && (N_W'(r_column) < w_n);

        swss_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_flags    (w_flags),
            .i_left_h   (w_left_h),
            .i_right_h  (w_right_h),
            .i_shift_in (w_shift_in),
            .o_height   (w_h[gi]),
            .o_shift    (w_shift[gi])
        );
    end

    // Output register: it parts the readout chain from the receiver.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_col  <= 5'(r_idx);
            r_out_h    <= w_shift[0];
            r_out_last <= (r_left == N_W'(1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_h, r_out_col};
    assign m_axis_tlast  = r_out_last;

    // The splash unit finishes only while the sequencer waits for it.
    a_splash_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_splash_done |-> (r_state == ST_SPLASH))
        else $error("splash result arrived outside the splash state");

    // The readout chain never advances while the output register is full and stalled.
    a_shift_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.op == OP_SHIFT) |-> (!r_out_valid || m_axis_tready))
        else $error("readout chain shifted into a stalled output register");

    // Once every height has been loaded into the output register, the sequencer returns to idle.
    a_out_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_left == '0) |=> (r_state == ST_IDLE))
        else $error("readout did not end after the final height");

endmodule
`default_nettype wire

// ===== sv/swss_cell.sv =====
// One water column: height, speed, a shared multiplier and a readout stage.
`default_nettype none
module swss_cell
    import swss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cell_ctrl            i_ctrl,
    input  wire t_cell_flags           i_flags,
    input  wire logic signed [Q_W-1:0] i_left_h,
    input  wire logic signed [Q_W-1:0] i_right_h,
    input  wire logic signed [Q_W-1:0] i_shift_in,
    output logic signed [Q_W-1:0]      o_height,
    output logic signed [Q_W-1:0]      o_shift
);

    logic signed [Q_W-1:0]    r_h;
    logic signed [Q_W-1:0]    r_s;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;
    logic signed [Q_W-1:0]    r_shift;

    logic signed [DIFF_W-1:0] w_h_ext;
    logic signed [DIFF_W-1:0] w_b;
    logic signed [COEF_W:0]   w_ca;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [SH_W-1:0]   w_a1;
    logic signed [SH_W-1:0]   w_a2;
    logic signed [ACC_W-1:0]  w_spring_sum;
    logic signed [ACC_W-1:0]  w_height_sum;
    logic signed [ACC_W-1:0]  w_d;
    logic signed [ACC_W-1:0]  w_s_spread;
    logic signed [ACC_W-1:0]  w_h_spread;

    assign w_h_ext = {r_h[Q_W-1], r_h};
    assign w_ca    = {1'b0, i_ctrl.coef};

    // Second multiplier operand follows the broadcast operation.
    always_comb begin
        w_b = '0;
        case (i_ctrl.op)
            OP_SPRING_T: w_b = $signed({2'b00, i_ctrl.rest}) - w_h_ext;
            OP_SPRING_D: w_b = {r_s[Q_W-1], r_s};
            OP_SPREAD_L: w_b = i_flags.left_en ? ({i_left_h[Q_W-1], i_left_h} - w_h_ext)
                                               : '0;
            OP_SPREAD_R: w_b = i_flags.right_en ? ({i_right_h[Q_W-1], i_right_h} - w_h_ext)
                                                : '0;
            default:     w_b = '0;
        endcase
    end

    assign w_prod = w_ca * w_b;

    // Taking the upper bits is the arithmetic shift by 16.
    assign w_a1 = r_p1[PROD_W-1:16];
    assign w_a2 = r_p2[PROD_W-1:16];

    assign w_spring_sum = ACC_W'(r_s) + ACC_W'(w_a1) - ACC_W'(w_a2);
    assign w_height_sum = ACC_W'(r_h) + ACC_W'(r_s);
    assign w_d          = ACC_W'(w_a1) + ACC_W'(w_a2);
    assign w_s_spread   = ACC_W'(r_s) + w_d;
    assign w_h_spread   = ACC_W'(r_h) + w_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= $signed({1'b0, REST_RESET});
            r_s <= '0;
        end else begin
            unique case (i_ctrl.op)
                OP_SPRING_S: begin
                    if (i_flags.active) r_s <= sat_q(w_spring_sum);
                end
                OP_SPRING_H: begin
                    if (i_flags.active) r_h <= sat_q(w_height_sum);
                end
                OP_SPREAD_U: begin
                    if (i_flags.active) begin
                        r_s <= sat_q(w_s_spread);
                        r_h <= sat_q(w_h_spread);
                    end
                end
                OP_RESTART: begin
                    r_h <= $signed({1'b0, i_ctrl.rest});
                    r_s <= '0;
                end
                OP_SPLASH: begin
                    if (i_flags.hit) r_s <= i_ctrl.splash_speed;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            OP_SPRING_T, OP_SPREAD_L: r_p1 <= w_prod;
            OP_SPRING_D, OP_SPREAD_R: r_p2 <= w_prod;
            OP_SNAP:                  r_shift <= r_h;
            OP_SHIFT:                 r_shift <= i_shift_in;
            default: begin
            end
        endcase
    end

    assign o_height = r_h;
    assign o_shift  = r_shift;

endmodule
`default_nettype wire

// ===== sv/swss_splash.sv =====
// Splash speed unit: weighted sum of velocity magnitudes, one multiplier used in turn for x and y.
`default_nettype none
module swss_splash
    import swss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic signed [23:0]    i_vel_x,
    input  wire logic signed [23:0]    i_vel_y,
    input  wire logic [COEF_W-1:0]     i_drag_x,
    input  wire logic [COEF_W-1:0]     i_drag_y,
    output logic                       o_done,
    output logic signed [Q_W-1:0]      o_speed
);

    logic [1:0]  r_cnt;
    logic [40:0] r_acc;

    logic [23:0]       w_mag_x;
    logic [23:0]       w_mag_y;
    logic [COEF_W-1:0] w_coef;
    logic [23:0]       w_mag;
    logic [39:0]       w_prod;

    // Magnitudes in unsigned 24 bits, so the most negative velocity stays exact.
    assign w_mag_x = i_vel_x[23] ? (~i_vel_x + 24'd1) : i_vel_x;
    assign w_mag_y = i_vel_y[23] ? (~i_vel_y + 24'd1) : i_vel_y;

    assign w_coef = (r_cnt == 2'd1) ? i_drag_x : i_drag_y;
    assign w_mag  = (r_cnt == 2'd1) ? w_mag_x : w_mag_y;
    assign w_prod = w_coef * w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (r_cnt != 2'd0) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (i_start) begin
            r_cnt <= 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cnt == 2'd1) begin
            r_acc <= 41'(w_prod);
        end else if (r_cnt == 2'd2) begin
            r_acc <= r_acc + 41'(w_prod);
        end
    end

    assign o_done  = (r_cnt == 2'd3);
    assign o_speed = (r_acc[40:35] != 6'd0) ? Q_MAX : $signed({1'b0, r_acc[34:12]});

endmodule
`default_nettype wire
